FILE: hdl/mhf_pkg.sv
`timescale 1ns / 1ps

package mhf_pkg;

	localparam int MAC_BITS = 48;
	localparam int CRC_BITS = 32;

	typedef logic [CRC_BITS-1:0] crc_t;
	typedef logic [MAC_BITS-1:0] mac_t;
	typedef logic [MAC_BITS-1:0][CRC_BITS-1:0] crc_masks_t;

	localparam crc_t CRC_POLY = 32'hEDB8_8320;
	localparam crc_t CRC_INIT = 32'hFFFF_FFFF;

	// reflected crc shift, low bit of the first byte first
	function automatic crc_t crc_shift(crc_t init, mac_t data);
		crc_t crc;
		crc = init;
		for (int i = 0; i < MAC_BITS; i++) begin
			if (crc[0] ^ data[i]) begin
				crc = (crc >> 1) ^ CRC_POLY;
			end else begin
				crc = crc >> 1;
			end
		end
		return crc;
	endfunction

	function automatic crc_masks_t build_masks();
		crc_masks_t m;
		for (int i = 0; i < MAC_BITS; i++) begin
			m[i] = crc_shift('0, mac_t'(1) << i);
		end
		return m;
	endfunction

	// crc is affine in the address bits: constant term plus one mask per set bit
	localparam crc_t CRC_BASE = ~crc_shift(CRC_INIT, '0);
	localparam crc_masks_t CRC_MASKS = build_masks();

	function automatic crc_t mac_crc(mac_t mac);
		crc_t crc;
		crc = CRC_BASE;
		for (int i = 0; i < MAC_BITS; i++) begin
			if (mac[i]) begin
				crc = crc ^ CRC_MASKS[i];
			end
		end
		return crc;
	endfunction

endpackage

FILE: hdl/multicast_hash_filter_set.sv
`timescale 1ns / 1ps

// channel  signals                            width
// in       in_valid in_ready mac_address      48
// out      out_valid out_ready word_index     7
//          bit_position word_value            5, 32
//
// each item goes through these steps in order: accept with table read, modify and
// write back, then the result moves into the output register.
// the table memory's single read port and registered read set these steps.
// after reset a clearing pass writes zeros over all 2**(HASH_BITS-5) table words
// (128 at the default) before the first item is taken.
// a stalled output holds the block in its last step until the earlier result in the output register is taken.

module multicast_hash_filter_set #(
	parameter int HASH_BITS = 12
) (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                in_valid,
	output logic                in_ready,
	input  mhf_pkg::mac_t       mac_address,
	output logic                out_valid,
	input  logic                out_ready,
	output logic [6:0]          word_index,
	output logic [4:0]          bit_position,
	output logic [31:0]         word_value
);
	import mhf_pkg::*;

	localparam int AW    = HASH_BITS - 5;
	localparam int WORDS = 2 ** AW;

	typedef enum logic [3:0] {
		ST_CLEAR  = 4'b0001,
		ST_IDLE   = 4'b0010,
		ST_MODIFY = 4'b0100,
		ST_SEND   = 4'b1000
	} state_t;

	state_t state_q;

	logic [31:0] table_mem [WORDS];

	crc_t            crc;
	logic [AW-1:0]   in_word;
	logic [4:0]      in_bit;
	logic            in_fire;
	logic            out_free;

	logic [AW-1:0]   clr_idx_q;
	logic [AW-1:0]   word_s1;
	logic [4:0]      bit_s1;
	logic [31:0]     rd_data_s1;
	logic [AW-1:0]   word_s2;
	logic [4:0]      bit_s2;
	logic [31:0]     value_s2;
	logic            out_valid_q;

	logic            mem_we;
	logic [AW-1:0]   mem_waddr;
	logic [31:0]     mem_wdata;
	logic [31:0]     new_value;

	assign crc      = mac_crc(mac_address);
	assign in_word  = crc[CRC_BITS-1 -: AW];
	assign in_bit   = crc[CRC_BITS-1-AW -: 5];
	assign in_ready = (state_q == ST_IDLE);
	assign in_fire  = in_valid && in_ready;
	assign out_free = !out_valid_q || out_ready;
	assign out_valid = out_valid_q;

	assign new_value = rd_data_s1 | (32'd1 << bit_s1);

	always_comb begin
		mem_we    = 1'b0;
		mem_waddr = word_s1;
		mem_wdata = new_value;
		case (state_q)
			ST_CLEAR: begin
				mem_we    = 1'b1;
				mem_waddr = clr_idx_q;
				mem_wdata = '0;
			end
			ST_MODIFY: begin
				mem_we = 1'b1;
			end
			default: begin
				mem_we = 1'b0;
			end
		endcase
	end

	always_ff @(posedge clk) begin
		if (mem_we) begin
			table_mem[mem_waddr] <= mem_wdata;
		end
		rd_data_s1 <= table_mem[in_word];
	end

	always_ff @(posedge clk) begin
		if (in_fire) begin
			word_s1 <= in_word;
			bit_s1  <= in_bit;
		end
		if (state_q == ST_MODIFY) begin
			word_s2  <= word_s1;
			bit_s2   <= bit_s1;
			value_s2 <= new_value;
		end
		if (state_q == ST_SEND && out_free) begin
			word_index   <= 7'(word_s2);
			bit_position <= bit_s2;
			word_value   <= value_s2;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_CLEAR;
			clr_idx_q   <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (state_q == ST_SEND && out_free) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
			case (state_q)
				ST_CLEAR: begin
					clr_idx_q <= clr_idx_q + 1'b1;
					if (&clr_idx_q) begin
						state_q <= ST_IDLE;
					end
				end
				ST_IDLE: begin
					if (in_fire) begin
						state_q <= ST_MODIFY;
					end
				end
				ST_MODIFY: begin
					state_q <= ST_SEND;
				end
				ST_SEND: begin
					if (out_free) begin
						state_q <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_CLEAR;
				end
			endcase
		end
	end

endmodule
